// ===== design/stable_priority_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue
// Shared helpers that wrap a concurrent assertion with clock and reset.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue package
// Depth, derived widths, operation and status codes, and payload types.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SERVE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  prio;
        logic [11:0] ticket;
        logic [31:0] tag;
    } t_entry;

    typedef struct packed {
        t_op         operation;
        logic [7:0]  priority_req;
        logic [11:0] ticket;
        logic [31:0] tag;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic             served_valid;
        logic [7:0]       served_priority;
        logic [11:0]      served_ticket;
        logic [31:0]      served_tag;
        logic [OCC_W-1:0] occupancy;
    } t_rsp;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic   insert;
        logic   serve;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

// ===== design/spq_if.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
interface spq_req_if;
    import spq_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue cell
// Holds one entry; keeps it, takes the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  spq_pkg::t_entry    i_left_entry,
    input  logic               i_left_after,
    input  spq_pkg::t_entry    i_right_entry,
    output spq_pkg::t_entry    o_entry,
    output logic               o_after
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // The chain is sorted, so this flag is high on a prefix of the cells and
    // the new entry lands in the first cell where it drops.
    assign o_after = i_occupied && (r_entry.prio >= i_ctl.new_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.serve) begin
            n_entry = i_right_entry;
        end else if (i_ctl.insert && !o_after) begin
            n_entry = i_left_after ? i_ctl.new_entry : i_left_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule

// ===== design/spq_outbuf.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue response buffer
// Output register plus skid stage between the queue and the response sink.
// ----------------------------------------------------------------------------
module spq_outbuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  spq_pkg::t_rsp i_data,
    output logic          o_ready,
    spq_rsp_if.source     o_rsp
);
    import spq_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_rsp r_out;
    t_rsp r_skid;
    logic w_take;

    assign w_take        = r_out_valid && o_rsp.ready;
    assign o_ready       = !r_skid_valid;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (i_push && r_out_valid && !w_take) begin
            r_skid <= i_data;
        end
    end
endmodule

// ===== design/stable_priority_queue_core.sv =====
// An accepted request's response is registered in the output or skid stage.
// Throughput: one insert or serve per cycle while the skid is empty; every
// cell updates in the same cycle; depth and occupancy do not affect the rate.
// A two-deep response buffer keeps requests flowing while one response waits.
// Synchronous active-low reset empties the queue and the response buffer;
// cell contents are not cleared and are only read below the entry count.
// ----------------------------------------------------------------------------
// Stable priority queue core
// Sorted chain of cells with first-in first-out order among equal priorities.
// ----------------------------------------------------------------------------
module stable_priority_queue_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);
    import spq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_buf_ready;
    t_cell_ctl        w_ctl;
    t_rsp             w_rsp;
    t_entry           w_entry [QUEUE_DEPTH];
    logic             w_after [QUEUE_DEPTH];

    assign i_req.ready = w_buf_ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);

    assign w_ctl.insert = w_accept && (i_req.payload.operation == OP_INSERT) && !w_full;
    assign w_ctl.serve  = w_accept && (i_req.payload.operation == OP_SERVE) && !w_empty;
    assign w_ctl.new_entry.prio   = i_req.payload.priority_req;
    assign w_ctl.new_entry.ticket = i_req.payload.ticket;
    assign w_ctl.new_entry.tag    = i_req.payload.tag;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic   w_occupied;
            t_entry w_left_entry;
            logic   w_left_after;
            t_entry w_right_entry;

            assign w_occupied = (CNT_W'(g) < r_count);

            if (g == 0) begin : g_head
                assign w_left_entry = w_ctl.new_entry;
                assign w_left_after = 1'b1;
            end else begin : g_body
                assign w_left_entry = w_entry[g-1];
                assign w_left_after = w_after[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_right_entry = w_entry[g];
            end else begin : g_inner
                assign w_right_entry = w_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occupied    (w_occupied),
                .i_left_entry  (w_left_entry),
                .i_left_after  (w_left_after),
                .i_right_entry (w_right_entry),
                .o_entry       (w_entry[g]),
                .o_after       (w_after[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.serve) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_comb begin
        w_rsp.status          = ST_DONE;
        w_rsp.served_valid    = w_ctl.serve;
        w_rsp.served_priority = w_ctl.serve ? w_entry[0].prio   : 8'd0;
        w_rsp.served_ticket   = w_ctl.serve ? w_entry[0].ticket : 12'd0;
        w_rsp.served_tag      = w_ctl.serve ? w_entry[0].tag    : 32'd0;
        w_rsp.occupancy       = OCC_W'(n_count);
        unique case (i_req.payload.operation)
            OP_INSERT: if (w_full)  w_rsp.status = ST_FULL;
            OP_SERVE:  if (w_empty) w_rsp.status = ST_EMPTY;
            default:   w_rsp.status = ST_DONE;
        endcase
    end

    spq_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_rsp),
        .o_ready (w_buf_ready),
        .o_rsp   (o_rsp)
    );
endmodule

// ===== design/spq_chk.sv =====
// ----------------------------------------------------------------------------
// Stable priority queue port checker
// Watches the response port for consistent status, occupancy and handshake.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_core_assert.svh"

module spq_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input spq_pkg::t_rsp i_rsp
);
    import spq_pkg::*;

    // A stalled response must stay in place until the sink takes it.
    `SPQ_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp), "response changed while stalled")

    // A rejected insert only happens with the queue at its full depth.
    `SPQ_ASSERT_IMPLY(a_full_occ, i_clk, i_rst_n, i_rsp_valid && (i_rsp.status == ST_FULL), (i_rsp.occupancy == OCC_W'(QUEUE_DEPTH)) && !i_rsp.served_valid, "full status with wrong occupancy")

    // A serve on an empty queue leaves it empty and returns nothing.
    `SPQ_ASSERT_IMPLY(a_empty_occ, i_clk, i_rst_n, i_rsp_valid && (i_rsp.status == ST_EMPTY), (i_rsp.occupancy == '0) && !i_rsp.served_valid && (i_rsp.served_tag == '0), "empty status with stale data")
endmodule

bind stable_priority_queue_core spq_chk u_spq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue core testbench
// Drives inserts and serves through the request channel, predicts every
// response from a sorted copy of the queue, and checks each field in order.
// ----------------------------------------------------------------------------
module tb;
    import spq_pkg::*;

    // Keeps the queue contents in service order and the responses still owed.
    class service_order_board;
        t_entry      held[QUEUE_DEPTH];
        int unsigned held_count;
        t_rsp        owed[$];
        int unsigned mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        function void note_request(t_req r);
            t_rsp   rsp;
            t_entry fresh;
            int     slot;
            rsp   = '0;
            fresh = '{prio: r.priority_req, ticket: r.ticket, tag: r.tag};
            rsp.status = ST_DONE;
            if (r.operation == OP_INSERT) begin
                if (held_count >= QUEUE_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    // The new entry goes behind every entry of equal or higher priority.
                    slot = 0;
                    while (slot < held_count && held[slot].prio >= fresh.prio)
                        slot++;
                    for (int i = held_count; i > slot; i--)
                        held[i] = held[i-1];
                    held[slot] = fresh;
                    held_count++;
                end
            end else begin
                if (held_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.served_valid    = 1'b1;
                    rsp.served_priority = held[0].prio;
                    rsp.served_ticket   = held[0].ticket;
                    rsp.served_tag      = held[0].tag;
                    for (int i = 1; i < held_count; i++)
                        held[i-1] = held[i];
                    held_count--;
                end
            end
            rsp.occupancy = held_count[OCC_W-1:0];
            owed.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (owed.size() == 0) begin
                $error("response arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.served_valid !== want.served_valid) begin
                $error("served_valid: expected %0d actual %0d",
                       want.served_valid, got.served_valid);
                mismatches++;
            end
            if (got.served_priority !== want.served_priority) begin
                $error("served_priority: expected %0d actual %0d",
                       want.served_priority, got.served_priority);
                mismatches++;
            end
            if (got.served_ticket !== want.served_ticket) begin
                $error("served_ticket: expected %0d actual %0d",
                       want.served_ticket, got.served_ticket);
                mismatches++;
            end
            if (got.served_tag !== want.served_tag) begin
                $error("served_tag: expected %h actual %h", want.served_tag, got.served_tag);
                mismatches++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d actual %0d", want.occupancy, got.occupancy);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction

        function void close();
            if (owed.size() != 0) begin
                $error("%0d responses never arrived", owed.size());
                mismatches += owed.size();
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bit          steady         = 1'b0;
    bit          hold_off_armed = 1'b0;
    bit          hold_off_done  = 1'b0;
    int unsigned hold_left      = 0;

    service_order_board board;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
    end

    // Response side: random back-pressure, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_off_armed && !hold_off_done) begin
            hold_off_done <= 1'b1;
            hold_left     <= 80;
            rsp_ch.ready  <= 1'b0;
        end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 28);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                board.note_request(req_ch.payload);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_response(rsp_ch.payload);
        end
    end

    function automatic t_req make_request(t_op op, logic [7:0] prio, logic [11:0] ticket,
                                          logic [31:0] tag);
        t_req r;
        r.operation    = op;
        r.priority_req = prio;
        r.ticket       = ticket;
        r.tag          = tag;
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(t_req r);
        while (!steady && $urandom_range(0, 99) < 28) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned insert_share;
        int unsigned drain_cycles;
        int unsigned share_plan[7];
        t_op         op;
        logic [7:0]  prio;

        share_plan = '{50, 85, 15, 60, 90, 10, 50};
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty serve, field extremes, ties, a full queue and a rejected insert.
        send_request(make_request(OP_SERVE, 8'd0, 12'd0, 32'd0));
        send_request(make_request(OP_INSERT, 8'd255, 12'd4095, 32'hFFFF_FFFF));
        send_request(make_request(OP_INSERT, 8'd0, 12'd0, 32'd0));
        send_request(make_request(OP_INSERT, 8'd128, 12'd1, 32'h0000_0001));
        send_request(make_request(OP_INSERT, 8'd128, 12'd2, 32'h0000_0002));
        send_request(make_request(OP_INSERT, 8'd128, 12'd3, 32'h0000_0003));
        send_request(make_request(OP_INSERT, 8'd255, 12'd5, 32'hA5A5_5A5A));
        send_request(make_request(OP_INSERT, 8'd0, 12'd6, 32'h5A5A_A5A5));
        for (int k = 0; k < 9; k++)
            send_request(make_request(OP_INSERT, 8'(k * 31), 12'(100 + k), $urandom));
        send_request(make_request(OP_INSERT, 8'd200, 12'd4095, 32'hFFFF_FFFF));
        for (int k = 0; k < 6; k++)
            send_request(make_request(OP_SERVE, 8'd255, 12'd4095, 32'hFFFF_FFFF));

        // The insert share changes every few hundred requests so that the queue
        // swings between empty and full.
        for (int n = 0; n < 1750; n++) begin
            if (n == 600)
                steady <= 1'b1;
            if (n == 900)
                steady <= 1'b0;
            if (n == 1200)
                hold_off_armed <= 1'b1;
            insert_share = share_plan[n / 250];
            op = ($urandom_range(0, 99) < insert_share) ? OP_INSERT : OP_SERVE;
            case ($urandom_range(0, 3))
                0: prio = 8'($urandom_range(0, 3));
                1: prio = 8'($urandom_range(252, 255));
                default: prio = 8'($urandom_range(0, 255));
            endcase
            send_request(make_request(op, prio, 12'($urandom_range(0, 4095)), $urandom));
        end
        req_ch.valid <= 1'b0;

        drain_cycles = 0;
        while (board.outstanding() != 0 && drain_cycles < 2000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        board.close();
        if (board.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/spq_pkg.sv
design/spq_if.sv
design/spq_cell.sv
design/spq_outbuf.sv
design/stable_priority_queue_core.sv
design/spq_chk.sv
tb/sv/tb.sv
